// ----- rtl/core/bdc_pkg.sv -----
// Shared constants and types for the B-dot detumble controller.
package bdc_pkg;

    localparam int COEF_W    = 24;
    localparam int DRIVE_W   = 16;
    localparam int NUM_AXES  = 3;
    localparam int FRAC_BITS = 15;
    // one integer step plus one step per fraction bit
    localparam int DIV_STEPS = FRAC_BITS + 1;
    // multiply, merge, divider steps, output format
    localparam int PIPE_STAGES = 2 + DIV_STEPS + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [63:0]        FULL_DRIVE     = 64'h0000_0000_8000_0000;
    localparam logic [FRAC_BITS-1:0] DRIVE_MAX    = 15'h7FFF;
    localparam logic [DRIVE_W-1:0] DRIVE_POS_FULL = 16'h7FFF;
    localparam logic [DRIVE_W-1:0] DRIVE_NEG_FULL = 16'h8001;
    localparam logic [DRIVE_W-1:0] DRIVE_NEG_OVF  = 16'h8000;
    localparam logic [COEF_W-1:0]  COEF_RESET     = 24'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_X = 2'd0,
        CFG_COEF_Y = 2'd1,
        CFG_COEF_Z = 2'd2
    } cfg_idx_t;

endpackage

// ----- rtl/core/bdc_if.sv -----
// Valid/ready channel interfaces for rate samples and drive results.
interface bdc_rate_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] rate_x;
    logic signed [SAMPLE_BITS-1:0] rate_y;
    logic signed [SAMPLE_BITS-1:0] rate_z;

    modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
    modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

interface bdc_drive_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_x;
    logic signed [15:0] drive_y;
    logic signed [15:0] drive_z;
    logic               was_scaled;

    modport source (output valid, output drive_x, output drive_y, output drive_z,
                    output was_scaled, input ready);
    modport sink   (input valid, input drive_x, input drive_y, input drive_z,
                    input was_scaled, output ready);
endinterface

// ----- rtl/core/bdc_mult.sv -----
// One axis lane: magnitude of -coef * rate, registered.
module bdc_mult #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                       clk,
    input  logic                                       en,
    input  logic signed [SAMPLE_BITS-1:0]              rate,
    input  logic [bdc_pkg::COEF_W-1:0]                 coef,
    output logic [bdc_pkg::COEF_W+SAMPLE_BITS-2:0]     mag_reg,
    output logic                                       neg_reg
);
    import bdc_pkg::*;

    localparam int MAG_W  = COEF_W + SAMPLE_BITS - 1;
    localparam int PROD_W = COEF_W + SAMPLE_BITS;

    logic                   rate_neg;
    logic [SAMPLE_BITS-1:0] rate_u;
    logic [SAMPLE_BITS-1:0] rate_mag;
    logic [PROD_W-1:0]      prod;
    logic [MAG_W-1:0]       mag_next;
    logic                   neg_next;

    always_comb
    begin
        rate_u   = rate;
        rate_neg = rate_u[SAMPLE_BITS-1];
        rate_mag = rate_neg ? (~rate_u + 1'b1) : rate_u;
        prod     = PROD_W'(coef) * PROD_W'(rate_mag);
        mag_next = prod[MAG_W-1:0];
        // drive opposes the rate
        neg_next = !rate_neg && (mag_next != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
    end

endmodule

// ----- rtl/core/bdc_merge.sv -----
// Merge stage: largest magnitude, scale decision and unscaled drive per lane.
module bdc_merge #(
    parameter int MAG_W = 47
) (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic [bdc_pkg::NUM_AXES-1:0][MAG_W-1:0]   mag,
    input  logic [bdc_pkg::NUM_AXES-1:0]              neg,
    output logic [bdc_pkg::NUM_AXES-1:0][MAG_W-1:0]   mag_reg,
    output logic [bdc_pkg::NUM_AXES-1:0]              neg_reg,
    output logic [bdc_pkg::NUM_AXES-1:0][bdc_pkg::FRAC_BITS-1:0] dns_reg,
    output logic [MAG_W-1:0]                          largest_reg,
    output logic                                      scaled_reg
);
    import bdc_pkg::*;

    logic [NUM_AXES-1:0][63:0]        m64;
    logic [NUM_AXES-1:0]              over;
    logic [NUM_AXES-1:0][16:0]        d17;
    logic [NUM_AXES-1:0][FRAC_BITS-1:0] dns_next;
    logic                             ge01;
    logic                             ge02;
    logic                             ge12;
    logic [MAG_W-1:0]                 largest_next;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            m64[i]  = 64'(mag[i]);
            over[i] = m64[i] > FULL_DRIVE;
            // floor of a negative drive rounds magnitude up
            d17[i]  = m64[i][32:16] + 17'(neg[i] && (m64[i][15:0] != '0));
            dns_next[i] = (d17[i] > 17'(DRIVE_MAX)) ? DRIVE_MAX : d17[i][FRAC_BITS-1:0];
        end
        ge01 = mag[0] >= mag[1];
        ge02 = mag[0] >= mag[2];
        ge12 = mag[1] >= mag[2];
        if (ge01 && ge02)
            largest_next = mag[0];
        else if (!ge01 && ge12)
            largest_next = mag[1];
        else
            largest_next = mag[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg     <= mag;
            neg_reg     <= neg;
            dns_reg     <= dns_next;
            largest_reg <= largest_next;
            scaled_reg  <= |over;
        end
    end

endmodule

// ----- rtl/core/bdc_div.sv -----
// One axis lane: pipelined restoring divider mag/largest in Q1.15 and output format.
module bdc_div #(
    parameter int MAG_W = 47
) (
    input  logic                              clk,
    input  logic [bdc_pkg::DIV_STEPS:0]       en,
    input  logic [MAG_W-1:0]                  mag,
    input  logic [MAG_W-1:0]                  largest,
    input  logic                              scaled,
    input  logic                              neg,
    input  logic [bdc_pkg::FRAC_BITS-1:0]     dns,
    output logic signed [bdc_pkg::DRIVE_W-1:0] drive_reg,
    output logic                              scaled_out_reg
);
    import bdc_pkg::*;

    logic [MAG_W-1:0]     rem_reg    [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg      [DIV_STEPS];
    logic [MAG_W-1:0]     m_reg      [DIV_STEPS];
    logic                 scaled_reg [DIV_STEPS];
    logic                 neg_reg    [DIV_STEPS];
    logic [FRAC_BITS-1:0] dns_reg    [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            logic [MAG_W-1:0]     rem_next;
            logic [DIV_STEPS-1:0] q_next;
            logic [MAG_W:0]       sh;
            logic [MAG_W:0]       diff;
            logic                 ge;

            if (k == 0)
            begin : g_first
                always_comb
                begin
                    sh       = {1'b0, mag};
                    diff     = sh - {1'b0, largest};
                    ge       = mag >= largest;
                    rem_next = ge ? diff[MAG_W-1:0] : mag;
                    q_next   = DIV_STEPS'(ge);
                end

                always_ff @(posedge clk)
                begin
                    if (en[k])
                    begin
                        rem_reg[k]    <= rem_next;
                        q_reg[k]      <= q_next;
                        m_reg[k]      <= largest;
                        scaled_reg[k] <= scaled;
                        neg_reg[k]    <= neg;
                        dns_reg[k]    <= dns;
                    end
                end
            end
            else
            begin : g_next
                always_comb
                begin
                    sh       = {rem_reg[k-1], 1'b0};
                    diff     = sh - {1'b0, m_reg[k-1]};
                    ge       = sh >= {1'b0, m_reg[k-1]};
                    rem_next = ge ? diff[MAG_W-1:0] : sh[MAG_W-1:0];
                    q_next   = {q_reg[k-1][DIV_STEPS-2:0], ge};
                end

                always_ff @(posedge clk)
                begin
                    if (en[k])
                    begin
                        rem_reg[k]    <= rem_next;
                        q_reg[k]      <= q_next;
                        m_reg[k]      <= m_reg[k-1];
                        scaled_reg[k] <= scaled_reg[k-1];
                        neg_reg[k]    <= neg_reg[k-1];
                        dns_reg[k]    <= dns_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    logic [FRAC_BITS-1:0]  dq;
    logic [FRAC_BITS-1:0]  d;
    logic [DRIVE_W-1:0]    d16;
    logic [DRIVE_W-1:0]    drive_next;

    always_comb
    begin
        // largest axis gives a quotient of exactly one
        dq = (q_reg[DIV_STEPS-1] > DIV_STEPS'(DRIVE_MAX)) ? DRIVE_MAX
                                                          : q_reg[DIV_STEPS-1][FRAC_BITS-1:0];
        d  = scaled_reg[DIV_STEPS-1] ? dq : dns_reg[DIV_STEPS-1];
        d16 = {1'b0, d};
        drive_next = neg_reg[DIV_STEPS-1] ? (~d16 + 1'b1) : d16;
    end

    always_ff @(posedge clk)
    begin
        if (en[DIV_STEPS])
        begin
            drive_reg      <= drive_next;
            scaled_out_reg <= scaled_reg[DIV_STEPS-1];
        end
    end

endmodule

// ----- rtl/core/bdot_detumble_control.sv -----
// Top level of the B-dot detumble controller.
// One three-axis rate sample in, one drive result out, one transfer per cycle sustained
// while drives.ready is high. Stages: one multiply stage per axis, one merge stage that
// finds the largest drive and decides on scaling, a 16-step pipelined restoring divider
// per axis, and an output register. Every stage holds its own valid bit and advances on
// its own, so bubbles collapse and new samples keep flowing into empty stages while a
// result waits at the output. The user must write coefficients through the cfg port
// only while the pipeline is empty; the block does not enforce this. Index 3 is ignored.
module bdot_detumble_control #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bdc_rate_if.sink                        rates,
    bdc_drive_if.source                     drives,
    input  logic                            cfg_we,
    input  logic [bdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdc_pkg::COEF_W-1:0]      cfg_data
);
    import bdc_pkg::*;

    localparam int MAG_W = COEF_W + SAMPLE_BITS - 1;

    logic [COEF_W-1:0] coef_x_reg;
    logic [COEF_W-1:0] coef_y_reg;
    logic [COEF_W-1:0] coef_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg <= COEF_RESET;
            coef_y_reg <= COEF_RESET;
            coef_z_reg <= COEF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COEF_X: coef_x_reg <= cfg_data;
                CFG_COEF_Y: coef_y_reg <= cfg_data;
                CFG_COEF_Z: coef_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and per-stage load enables
    logic [PIPE_STAGES-1:0] v_reg;
    logic [PIPE_STAGES-1:0] v_next;
    logic [PIPE_STAGES-1:0] en;

    genvar s;
    generate
        for (s = 0; s < PIPE_STAGES; s++)
        begin : g_en
            // a stage loads when it or any later stage has a hole, or the output drains
            assign en[s] = drives.ready || !(&v_reg[PIPE_STAGES-1:s]);
        end
    endgenerate

    always_comb
    begin
        v_next = v_reg;
        for (int i = 0; i < PIPE_STAGES; i++)
        begin
            if (en[i])
                v_next[i] = (i == 0) ? rates.valid : v_reg[(i == 0) ? 0 : i - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign rates.ready = en[0];

    // multiply lanes
    logic [NUM_AXES-1:0][MAG_W-1:0] mul_mag;
    logic [NUM_AXES-1:0]            mul_neg;

    bdc_mult #(.SAMPLE_BITS(SAMPLE_BITS)) u_mult_x (
        .clk(clk), .en(en[0]), .rate(rates.rate_x), .coef(coef_x_reg),
        .mag_reg(mul_mag[0]), .neg_reg(mul_neg[0])
    );
    bdc_mult #(.SAMPLE_BITS(SAMPLE_BITS)) u_mult_y (
        .clk(clk), .en(en[0]), .rate(rates.rate_y), .coef(coef_y_reg),
        .mag_reg(mul_mag[1]), .neg_reg(mul_neg[1])
    );
    bdc_mult #(.SAMPLE_BITS(SAMPLE_BITS)) u_mult_z (
        .clk(clk), .en(en[0]), .rate(rates.rate_z), .coef(coef_z_reg),
        .mag_reg(mul_mag[2]), .neg_reg(mul_neg[2])
    );

    // merge
    logic [NUM_AXES-1:0][MAG_W-1:0]     mrg_mag;
    logic [NUM_AXES-1:0]                mrg_neg;
    logic [NUM_AXES-1:0][FRAC_BITS-1:0] mrg_dns;
    logic [MAG_W-1:0]                   mrg_largest;
    logic                               mrg_scaled;

    bdc_merge #(.MAG_W(MAG_W)) u_merge (
        .clk(clk), .en(en[1]), .mag(mul_mag), .neg(mul_neg),
        .mag_reg(mrg_mag), .neg_reg(mrg_neg), .dns_reg(mrg_dns),
        .largest_reg(mrg_largest), .scaled_reg(mrg_scaled)
    );

    // divider lanes
    logic signed [DRIVE_W-1:0] drv [NUM_AXES];
    logic [NUM_AXES-1:0]       drv_scaled;

    genvar a;
    generate
        for (a = 0; a < NUM_AXES; a++)
        begin : g_div
            bdc_div #(.MAG_W(MAG_W)) u_div (
                .clk(clk), .en(en[PIPE_STAGES-1:2]),
                .mag(mrg_mag[a]), .largest(mrg_largest), .scaled(mrg_scaled),
                .neg(mrg_neg[a]), .dns(mrg_dns[a]),
                .drive_reg(drv[a]), .scaled_out_reg(drv_scaled[a])
            );
        end
    endgenerate

    assign drives.valid      = v_reg[PIPE_STAGES-1];
    assign drives.drive_x    = drv[0];
    assign drives.drive_y    = drv[1];
    assign drives.drive_z    = drv[2];
    assign drives.was_scaled = |drv_scaled;

endmodule

// ----- rtl/core/bdc_checker.sv -----
// Port-level checks for the B-dot detumble controller, bound to the top level.
module bdc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bdc_pkg::DRIVE_W-1:0]   drive_x,
    input logic [bdc_pkg::DRIVE_W-1:0]   drive_y,
    input logic [bdc_pkg::DRIVE_W-1:0]   drive_z,
    input logic                          was_scaled
);
    import bdc_pkg::*;

    // drive stays symmetric
    a_no_neg_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_x != DRIVE_NEG_OVF) && (drive_y != DRIVE_NEG_OVF)
                      && (drive_z != DRIVE_NEG_OVF))
        else $error("drive at -32768");

    // a scaled result has its largest axis at full drive
    a_scaled_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_scaled) |->
            (drive_x == DRIVE_POS_FULL) || (drive_x == DRIVE_NEG_FULL) ||
            (drive_y == DRIVE_POS_FULL) || (drive_y == DRIVE_NEG_FULL) ||
            (drive_z == DRIVE_POS_FULL) || (drive_z == DRIVE_NEG_FULL))
        else $error("scaled result without a full-drive axis");

    // a draining output frees the whole pipeline
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(drive_x) && $stable(drive_y)
                                      && $stable(drive_z) && $stable(was_scaled))
        else $error("stalled result changed");

endmodule

bind bdot_detumble_control bdc_checker u_bdc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(rates.ready),
    .out_valid(drives.valid),
    .out_ready(drives.ready),
    .drive_x(drives.drive_x),
    .drive_y(drives.drive_y),
    .drive_z(drives.drive_z),
    .was_scaled(drives.was_scaled)
);
